/* design/lz_phrase_decoder_defines.svh */
// Assertion macros shared by the phrase decoder RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef LZ_PHRASE_DECODER_DEFINES_SVH
`define LZ_PHRASE_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZPD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lz_phrase_decoder: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LZPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lz_phrase_decoder: next-cycle check failed");

`endif

/* design/lzpd_pkg.sv */
// Package for the phrase decoder: widths and the input and result payload types.
// No dependencies.
`timescale 1ns / 1ps

package lzpd_pkg;

    localparam int POS_W  = 32;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    typedef struct packed {
        logic [POS_W-1:0] literal_or_position;
        logic [LEN_W-1:0] copy_length;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              error;
    } t_out;

endpackage

/* design/lz_phrase_decoder.sv */
// Phrase decoder: literal and copy phrases against a circular byte history.
// Depends on lzpd_pkg and lz_phrase_decoder_defines.svh.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------
//   input    | i_in_valid / o_in_stall    | i_in_data  (t_in)
//   output   | o_out_valid / i_out_stall  | o_out_data (t_out)
//
// A literal or a rejected copy is accepted and gives one registered result.
// A copy of N bytes gives N results: after it is accepted, the history read port
// reads one byte per cycle while the output does not stall; each read is registered.
// Reset (synchronous, active low) clears the byte count and all control state;
// the history memory itself is not cleared, since only written entries are read.
// A stall on the output holds the pending history read until the result slot frees.
`timescale 1ns / 1ps
`include "lz_phrase_decoder_defines.svh"

module lz_phrase_decoder #(
    parameter int HIST_DEPTH = 4096,
    parameter int MAX_COPY   = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lzpd_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lzpd_pkg::t_out o_out_data
);
    import lzpd_pkg::*;

    localparam int              AW        = $clog2(HIST_DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(HIST_DEPTH - 1);
    localparam logic [AW:0]     DEPTH_V   = (AW + 1)'(HIST_DEPTH);
    localparam logic [POS_W-1:0] DEPTH_P  = POS_W'(HIST_DEPTH);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_COPY);

    logic [BYTE_W-1:0] r_hist [HIST_DEPTH];

    logic [POS_W-1:0]  r_count;
    logic [AW-1:0]     r_wr_addr;
    logic [AW-1:0]     r_src;
    logic [LEN_W-1:0]  r_left;
    logic              r_pend;
    logic              r_pend_last;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_fwd_byte;
    logic [BYTE_W-1:0] r_rd_q;
    logic              r_ov;
    t_out              r_out;

    logic [POS_W-1:0]  n_count;
    logic [AW-1:0]     n_wr_addr;
    logic [AW-1:0]     n_src;
    logic [LEN_W-1:0]  n_left;
    logic              n_pend;
    logic              n_pend_last;
    logic              n_fwd;
    logic              n_ov;
    t_out              n_out;

    logic              busy;
    logic              out_free;
    logic              in_acc;
    logic              is_lit;
    logic              bad;
    logic [POS_W-1:0]  back_gap;
    logic [AW:0]       src_diff;
    logic [AW-1:0]     src0;
    logic              consume;
    logic              issue;
    logic [BYTE_W-1:0] cons_byte;
    logic              we;
    logic [BYTE_W-1:0] wdata;

    assign busy     = (r_left != '0) || r_pend;
    assign out_free = !r_ov || !i_out_stall;
    assign o_in_stall = busy || !out_free;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_lit   = (i_in_data.copy_length == '0);

    // Distance back from the write point; valid copies have 1 <= back_gap <= HIST_DEPTH.
    assign back_gap = r_count - i_in_data.literal_or_position;
    assign bad  = (i_in_data.copy_length > MAX_LEN)
               || (i_in_data.literal_or_position >= r_count)
               || (back_gap > DEPTH_P);

    // The first source entry is the write address stepped back by back_gap, modulo the depth.
    assign src_diff = {1'b0, r_wr_addr} - back_gap[AW:0];
    assign src0     = src_diff[AW] ? AW'(src_diff + DEPTH_V) : src_diff[AW-1:0];

    assign consume   = r_pend && out_free;
    assign issue     = (r_left != '0) && (!r_pend || consume);
    assign cons_byte = r_fwd ? r_fwd_byte : r_rd_q;

    assign we    = (in_acc && is_lit) || consume;
    assign wdata = consume ? cons_byte : i_in_data.literal_or_position[BYTE_W-1:0];

    always_comb begin
        n_count     = r_count;
        n_wr_addr   = r_wr_addr;
        n_src       = r_src;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_fwd       = r_fwd;
        n_ov        = r_ov && i_out_stall;
        n_out       = r_out;

        if (we) begin
            n_count = r_count + POS_W'(1);
            // The write address tracks the count modulo the depth, so it restarts
            // both at the end of the memory and when the count itself wraps.
            if ((r_count == '1) || (r_wr_addr == LAST_ADDR)) begin
                n_wr_addr = '0;
            end else begin
                n_wr_addr = r_wr_addr + AW'(1);
            end
        end

        if (in_acc) begin
            if (is_lit) begin
                n_ov  = 1'b1;
                n_out = '{out_byte: i_in_data.literal_or_position[BYTE_W-1:0],
                          last: 1'b1, error: 1'b0};
            end else if (bad) begin
                n_ov  = 1'b1;
                n_out = '{out_byte: '0, last: 1'b1, error: 1'b1};
            end else begin
                n_left = i_in_data.copy_length;
                n_src  = src0;
            end
        end

        if (consume) begin
            n_ov   = 1'b1;
            n_out  = '{out_byte: cons_byte, last: r_pend_last, error: 1'b0};
            n_pend = 1'b0;
            n_fwd  = 1'b0;
        end

        if (issue) begin
            n_pend      = 1'b1;
            n_pend_last = (r_left == LEN_W'(1));
            n_left      = r_left - LEN_W'(1);
            n_src       = (r_src == LAST_ADDR) ? '0 : r_src + AW'(1);
            // A read of the entry written in this same cycle returns the old byte,
            // so the byte being written is carried over instead.
            n_fwd       = consume && (r_src == r_wr_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_hist[r_wr_addr] <= wdata;
        end
        if (issue) begin
            r_rd_q <= r_hist[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wr_addr <= '0;
            r_src     <= '0;
            r_left    <= '0;
            r_pend    <= 1'b0;
            r_fwd     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_wr_addr <= n_wr_addr;
            r_src     <= n_src;
            r_left    <= n_left;
            r_pend    <= n_pend;
            r_fwd     <= n_fwd;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
        if (consume) begin
            r_fwd_byte <= cons_byte;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `LZPD_ASSERT_NEXT(a_count_step, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + POS_W'(1)))
    `LZPD_ASSERT_SAME(a_fwd_needs_pend, r_fwd, r_pend)
    `LZPD_ASSERT_SAME(a_addr_range, 1'b1, (r_wr_addr <= LAST_ADDR) && (r_src <= LAST_ADDR))
    `LZPD_ASSERT_SAME(a_error_form, o_out_valid && o_out_data.error, o_out_data.last && (o_out_data.out_byte == '0))
    `LZPD_ASSERT_SAME(a_no_accept_busy, in_acc, (r_left == '0) && !r_pend)

endmodule
